// ===== rtl/core/rfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants of the response frame checker: header layout,
// verdict codes and the per-byte result record.
// ----------------------------------------------------------------------------
package rfc_pkg;

  // Frame layout: header bytes, then payload, then one checksum byte.
  localparam int HEADER_BYTES = 6;
  // The position counter reaches HEADER_BYTES + 255 at most.
  localparam int POS_W        = 9;

  // Header byte positions that are checked.
  localparam logic [POS_W-1:0] POS_START    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ADDR     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADDR_INV = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_BYTES);

  // Verdict reported with the checksum byte.
  typedef enum logic [1:0] {
    STATUS_BUSY    = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_HDR_ERR = 2'd2,
    STATUS_SUM_ERR = 2'd3
  } status_t;

  // One result per received byte.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    status_t    frame_status;
  } result_t;

endpackage : rfc_pkg
`default_nettype wire

// ===== rtl/core/response_frame_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// response_frame_checker
// Byte-at-a-time checker for meter response frames with an inverted 8-bit
// sum checksum.
// ----------------------------------------------------------------------------
// Each received byte yields exactly one result transaction. Bytes are taken at
// one per clock: a byte is held in the input register, where the frame logic
// evaluates it and updates the frame state as it moves into the result
// register, so throughput is one transaction per cycle whenever out_stall is
// low. A frame is six header bytes, the payload, and a checksum byte; the
// payload length is sampled from in_expected_length on the frame's first
// byte. Payload bytes come out with out_payload_valid set; the checksum byte
// comes out with out_frame_done set and the verdict in out_frame_status (1 ok,
// 2 header mismatch, 3 checksum mismatch, header mismatch taking precedence).
// Write cfg_wr_data with the meter address only while no transaction is in
// flight.
module response_frame_checker
  import rfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration port.
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  // Received byte channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] in_expected_length,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_payload_valid,
  output logic [7:0]      out_payload_byte,
  output logic            out_frame_done,
  output logic [1:0]      out_frame_status
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_len_r;
  logic       s1_adv;
  logic       out_can_load;
  logic       in_take;
  logic       frame_idle;
  result_t    core_res;
  result_t    out_res;

  // The input register moves on when the result register can take it.
  assign s1_adv   = s1_valid_r && out_can_load;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
      s1_len_r  <= in_expected_length;
    end
  end

  // Frame checks and state.
  rfc_frame_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .take            (s1_adv),
    .rx_byte         (s1_byte_r),
    .expected_length (s1_len_r),
    .result          (core_res),
    .frame_idle      (frame_idle)
  );

  // Result register.
  rfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv),
    .res_in    (core_res),
    .can_load  (out_can_load),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_frame_done    = out_res.frame_done;
  assign out_frame_status  = out_res.frame_status;

  // A finished frame leaves the tracker waiting for a new start byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && core_res.frame_done) |=> frame_idle)
    else $error("frame state not cleared after checksum byte");

  // A verdict appears exactly on the end-of-frame result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_done == (out_frame_status != STATUS_BUSY)))
    else $error("verdict and end-of-frame flag disagree");

  // A byte held in the input register is not dropped while stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input register lost a pending byte");

endmodule : response_frame_checker
`default_nettype wire

// ===== rtl/core/rfc_frame_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_frame_core
// Frame tracking state, header checks and the running checksum. Produces the
// result for the byte at its input and updates the frame state when that
// byte is taken.
// ----------------------------------------------------------------------------
module rfc_frame_core
  import rfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] expected_length,
  output result_t         result,
  output logic            frame_idle
);

  logic [7:0]       dev_addr_r;
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [7:0]       sum_r,    sum_nxt;
  logic             hdr_bad_r, hdr_bad_nxt;
  logic [7:0]       len_r,    len_nxt;

  logic [7:0]       len_cur;
  logic [POS_W-1:0] csum_pos;
  logic             is_csum;
  logic             hdr_mismatch;

  // The length is sampled on the first byte of a frame.
  assign len_cur  = (pos_r == POS_START) ? expected_length : len_r;
  assign csum_pos = POS_PAYLOAD + POS_W'(len_cur);
  assign is_csum  = (pos_r == csum_pos);

  // Header field checks against the configured address and the length.
  always_comb begin
    hdr_mismatch = 1'b0;
    if ((pos_r == POS_ADDR) && (rx_byte != dev_addr_r)) begin
      hdr_mismatch = 1'b1;
    end
    if ((pos_r == POS_ADDR_INV) && (rx_byte != ~dev_addr_r)) begin
      hdr_mismatch = 1'b1;
    end
    if ((pos_r == POS_LENGTH) && (rx_byte != len_cur)) begin
      hdr_mismatch = 1'b1;
    end
  end

  // Result and next frame state for the current byte.
  always_comb begin
    result.payload_valid = 1'b0;
    result.payload_byte  = 8'd0;
    result.frame_done    = 1'b0;
    result.frame_status  = STATUS_BUSY;
    pos_nxt              = pos_r;
    sum_nxt              = sum_r;
    hdr_bad_nxt          = hdr_bad_r;
    len_nxt              = len_cur;
    if (is_csum) begin
      result.frame_done = 1'b1;
      if (hdr_bad_r) begin
        result.frame_status = STATUS_HDR_ERR;
      end else if (rx_byte != ~sum_r) begin
        result.frame_status = STATUS_SUM_ERR;
      end else begin
        result.frame_status = STATUS_OK;
      end
      pos_nxt     = POS_START;
      sum_nxt     = 8'd0;
      hdr_bad_nxt = 1'b0;
      len_nxt     = 8'd0;
    end else begin
      if (pos_r >= POS_PAYLOAD) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
      end
      hdr_bad_nxt = hdr_bad_r | hdr_mismatch;
      sum_nxt     = sum_r + rx_byte;
      pos_nxt     = pos_r + POS_W'(1);
    end
  end

  // Configuration register and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd0;
      pos_r      <= POS_START;
      sum_r      <= 8'd0;
      hdr_bad_r  <= 1'b0;
      len_r      <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
      if (take) begin
        pos_r     <= pos_nxt;
        sum_r     <= sum_nxt;
        hdr_bad_r <= hdr_bad_nxt;
        len_r     <= len_nxt;
      end
    end
  end

  assign frame_idle = (pos_r == POS_START);

endmodule : rfc_frame_core
`default_nettype wire

// ===== rtl/core/rfc_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_out_stage
// Result register of the checker. It loads a new result whenever it is empty
// or its current result leaves in the same cycle.
// ----------------------------------------------------------------------------
module rfc_out_stage
  import rfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         can_load,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      res_out
);

  logic    valid_r;
  result_t res_r;

  assign can_load = !valid_r || !out_stall;

  // Valid flag: set on load, cleared when the held result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule : rfc_out_stage
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the response frame checker. A short table of hand
// written frames comes first, then random frames with random content, some
// of them flawed or cut short, mixed with stray bytes. Every byte's result is
// predicted in the bench and compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import rfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BYTES = 400;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // Results that the hand written table spells out directly.
  localparam result_t RES_QUIET   = '0;
  localparam result_t RES_OK      = '{1'b0, 8'h00, 1'b1, STATUS_OK};
  localparam result_t RES_HDR_ERR = '{1'b0, 8'h00, 1'b1, STATUS_HDR_ERR};
  localparam result_t RES_SUM_ERR = '{1'b0, 8'h00, 1'b1, STATUS_SUM_ERR};

  typedef struct packed {
    logic [7:0] rx;
    logic [7:0] len;
    logic       known;
    result_t    want;
  } frame_row_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_ADDR,
    FLAW_ADDR_INV,
    FLAW_LENGTH,
    FLAW_SUM,
    FLAW_CUT
  } flaw_t;

  // Hand written frames at the reset address 0: an empty frame that passes,
  // a frame with both a bad address and a bad checksum (header error wins),
  // and a one-byte frame with a bad checksum. Lengths on later bytes vary
  // since only the first byte's length counts.
  localparam frame_row_t FRAME_TABLE [24] = '{
    '{8'hFF, 8'h00, 1'b1, RES_QUIET},
    '{8'h00, 8'hFF, 1'b1, RES_QUIET},
    '{8'hFF, 8'h80, 1'b1, RES_QUIET},
    '{8'h12, 8'h01, 1'b1, RES_QUIET},
    '{8'h34, 8'h7F, 1'b1, RES_QUIET},
    '{8'h00, 8'hAA, 1'b1, RES_QUIET},
    '{8'hBB, 8'h55, 1'b1, RES_OK},
    '{8'h00, 8'h02, 1'b1, RES_QUIET},
    '{8'h55, 8'hFF, 1'b1, RES_QUIET},
    '{8'hFF, 8'h00, 1'b1, RES_QUIET},
    '{8'h00, 8'h10, 1'b1, RES_QUIET},
    '{8'h00, 8'h20, 1'b1, RES_QUIET},
    '{8'h02, 8'h40, 1'b1, RES_QUIET},
    '{8'h00, 8'h08, 1'b0, RES_QUIET},
    '{8'hFF, 8'h04, 1'b0, RES_QUIET},
    '{8'h00, 8'hFF, 1'b1, RES_HDR_ERR},
    '{8'h01, 8'h01, 1'b1, RES_QUIET},
    '{8'h00, 8'hFE, 1'b1, RES_QUIET},
    '{8'hFF, 8'h00, 1'b1, RES_QUIET},
    '{8'h7F, 8'h33, 1'b1, RES_QUIET},
    '{8'h80, 8'hCC, 1'b1, RES_QUIET},
    '{8'h01, 8'h0F, 1'b1, RES_QUIET},
    '{8'h80, 8'hF0, 1'b0, RES_QUIET},
    '{8'h00, 8'h00, 1'b1, RES_SUM_ERR}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic [7:0] in_expected_length = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic       out_frame_done;
  logic [1:0] out_frame_status;

  // Predicted frame state and the address register.
  logic [POS_W-1:0] fr_pos = '0;
  logic [7:0]       fr_sum = '0;
  logic             fr_hdr_bad = 1'b0;
  logic [7:0]       fr_len = '0;
  logic [7:0]       meter_addr = '0;

  result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int frames_ok = 0;
  int frames_hdr_err = 0;
  int frames_sum_err = 0;
  int mismatches = 0;
  int cycles = 0;

  response_frame_checker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_expected_length (in_expected_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_done     (out_frame_done),
    .out_frame_status   (out_frame_status)
  );

  always #5 clk = ~clk;

  // Advance the predicted frame by one byte and return the result it causes.
  function automatic result_t predict_frame_byte(logic [7:0] rx, logic [7:0] len);
    result_t res;
    res = RES_QUIET;
    if (fr_pos == POS_START) begin
      fr_len = len;
    end
    if (fr_pos == POS_PAYLOAD + POS_W'(fr_len)) begin
      res.frame_done = 1'b1;
      if (fr_hdr_bad) begin
        res.frame_status = STATUS_HDR_ERR;
      end else if (rx != ~fr_sum) begin
        res.frame_status = STATUS_SUM_ERR;
      end else begin
        res.frame_status = STATUS_OK;
      end
      fr_pos = '0;
      fr_sum = '0;
      fr_hdr_bad = 1'b0;
      fr_len = '0;
    end else begin
      if (fr_pos == POS_ADDR && rx != meter_addr) fr_hdr_bad = 1'b1;
      if (fr_pos == POS_ADDR_INV && rx != ~meter_addr) fr_hdr_bad = 1'b1;
      if (fr_pos == POS_LENGTH && rx != fr_len) fr_hdr_bad = 1'b1;
      if (fr_pos >= POS_PAYLOAD) begin
        res.payload_valid = 1'b1;
        res.payload_byte = rx;
      end
      fr_sum = fr_sum + rx;
      fr_pos = fr_pos + POS_W'(1);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one byte, wait for the transaction, then record its expected result.
  task automatic send_byte(logic [7:0] rx, logic [7:0] len, logic known, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    in_expected_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_frame_byte(rx, len);
    expected_results.push_back(known ? want : predicted);
    bytes_sent++;
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] addr);
    drain_results();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    meter_addr = addr;
  endtask

  // Build a frame for the current address, optionally spoil it, and send it.
  task automatic send_frame(logic [7:0] len, flaw_t flaw);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] spoil;
    int count;
    frame_bytes = {};
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(meter_addr);
    frame_bytes.push_back(~meter_addr);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(len);
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    sum = '0;
    foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
    frame_bytes.push_back(~sum);
    spoil = 8'($urandom_range(1, 255));
    count = frame_bytes.size();
    case (flaw)
      FLAW_ADDR: begin
        frame_bytes[1] ^= spoil;
      end
      FLAW_ADDR_INV: begin
        frame_bytes[2] ^= spoil;
      end
      FLAW_LENGTH: begin
        frame_bytes[5] ^= spoil;
      end
      FLAW_SUM: begin
        frame_bytes[count-1] ^= spoil;
      end
      FLAW_CUT: begin
        count = $urandom_range(1, count - 1);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < count; i++) begin
      send_byte(frame_bytes[i], (i == 0) ? len : 8'($urandom), 1'b0, RES_QUIET);
    end
  endtask

  // Mostly good frames with short payloads, a few long ones, some flawed frames,
  // a little line noise, and optionally a drain pause and a receiver hold-off.
  task automatic run_random_phase(int target, int pause_at, int hold_at);
    int start_count;
    int pick;
    logic [7:0] len;
    logic paused;
    logic held;
    start_count = bytes_sent;
    paused = 1'b0;
    held = 1'b0;
    while (bytes_sent - start_count < target) begin
      if (!paused && pause_at >= 0 && bytes_sent - start_count >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
      if (!held && hold_at >= 0 && bytes_sent - start_count >= hold_at) begin
        hold_req++;
        held = 1'b1;
      end
      len = ($urandom_range(99) < 3) ? 8'($urandom_range(13, 255))
                                     : 8'($urandom_range(0, 12));
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame(len, FLAW_NONE);
      end else if (pick < 96) begin
        send_frame(len, flaw_t'($urandom_range(FLAW_ADDR, FLAW_CUT)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom), 8'($urandom), 1'b0, RES_QUIET);
        end
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_payload_byte), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_payload_valid != want.payload_valid)
          report_mismatch("payload_valid", int'(out_payload_valid),
                          int'(want.payload_valid));
        if (out_payload_byte != want.payload_byte)
          report_mismatch("payload_byte", int'(out_payload_byte),
                          int'(want.payload_byte));
        if (out_frame_done != want.frame_done)
          report_mismatch("frame_done", int'(out_frame_done), int'(want.frame_done));
        if (out_frame_status != want.frame_status)
          report_mismatch("frame_status", int'(out_frame_status),
                          int'(want.frame_status));
        if (want.frame_done) begin
          case (want.frame_status)
            STATUS_OK:      frames_ok++;
            STATUS_HDR_ERR: frames_hdr_err++;
            STATUS_SUM_ERR: frames_sum_err++;
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("response_frame_checker: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset address.
    send_idle_pct = 25;
    recv_stall_pct = 75;
    foreach (FRAME_TABLE[i]) begin
      send_byte(FRAME_TABLE[i].rx, FRAME_TABLE[i].len, FRAME_TABLE[i].known,
                FRAME_TABLE[i].want);
    end

    // Random frames at the top address, including one full-length frame.
    write_address(8'hFF);
    send_frame(8'd255, FLAW_NONE);
    run_random_phase(PHASE_BYTES - 262, -1, -1);

    // Sender mostly idle; partway through it waits for the block to empty.
    write_address(8'($urandom));
    send_idle_pct = 75;
    recv_stall_pct = 25;
    run_random_phase(PHASE_BYTES, PHASE_BYTES / 2, -1);

    // Full rate, with one long hold-off at the receiver.
    write_address(8'h00);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(PHASE_BYTES, -1, 50);

    write_address(8'($urandom));
    run_random_phase(PHASE_BYTES, -1, -1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d bytes over %0d frames: %0d ok, %0d header errors, %0d checksum errors.",
             bytes_checked, frames_ok + frames_hdr_err + frames_sum_err, frames_ok,
             frames_hdr_err, frames_sum_err);
    $display("Addresses 0x00 and 0xFF plus random ones; lengths 0 through 255; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("response_frame_checker: match");
    end else begin
      $display("response_frame_checker: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rfc_pkg.sv
rtl/core/rfc_frame_core.sv
rtl/core/rfc_out_stage.sv
rtl/core/response_frame_checker.sv
sim/testbench.sv
